/* hdl/bilinear_texture_sampler_top_defines.svh */
// assertion macros for the bilinear texture sampler
// no dependencies
`ifndef BILINEAR_TEXTURE_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_TOP_DEFINES_SVH
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/bts_pkg.sv */
// shared types, constants and the lerp function for the bilinear texture sampler
// no dependencies
package bts_pkg;
  localparam int MAX_TEXELS_DEF = 4096;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam logic [31:0] WHITE = 32'hFFFFFFFF;
  localparam logic [7:0] ALPHA_ON = 8'hFF;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam logic [6:0] DIM_RESET = 7'd64;
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    PATH_RAW,
    PATH_VERT,
    PATH_HORZ,
    PATH_BOTH
  } path_t;

  function automatic logic [31:0] lerp_rgb(input logic [31:0] p, input logic [31:0] q,
                                           input logic [16:0] w, input int wb);
    logic [31:0] r;
    logic [16:0] s;
    logic [25:0] t;
    begin
      s = 17'd1 << wb;
      r = {ALPHA_ON, 24'd0};
      for (int c = 0; c < 3; c++) begin
        t = 26'(p[c*8 +: 8]) * 26'(s - w) + 26'(q[c*8 +: 8]) * 26'(w);
        r[c*8 +: 8] = 8'(t >> wb);
      end
      return r;
    end
  endfunction
endpackage

/* hdl/bilinear_texture_sampler_top.sv */
// Bilinear RGB888 texture sampler. One request per cycle is taken unless the
// output is stalled; a sample passes five register stages (scale multiply,
// index form, four-port store read, column lerp, row lerp), and a stall holds
// every stage. A texel write is registered before it lands in the store,
// so earlier samples read the old word and later ones the new; writes give
// no result.
// uses bts_pkg, bts_addr, bts_fetch, bts_filter and the defines header
`include "bilinear_texture_sampler_top_defines.svh"
module bilinear_texture_sampler_top #(
  parameter int MAX_TEXELS = bts_pkg::MAX_TEXELS_DEF,
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic op,
  input  logic [15:0] u_coord,
  input  logic [15:0] v_coord,
  input  logic [11:0] texel_index,
  input  logic [31:0] texel_argb,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] color_argb,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [6:0] cfg_data
);
  import bts_pkg::*;
  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
  logic adv, acc;
  logic [6:0] tex_width, tex_height;
  logic a_valid, f_valid, fo_valid;
  logic [3:0][AW-1:0] idx;
  logic [3:0] oob, oob_r;
  path_t path, path_r;
  logic [WEIGHT_BITS-1:0] wx, wy, wx_r, wy_r;
  logic [3:0][31:0] rd, texel;
  logic wr_v;
  logic [AW-1:0] wr_a;
  logic [31:0] wr_d;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width <= DIM_RESET;
      tex_height <= DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) tex_width <= cfg_data;
      else tex_height <= cfg_data;
    end
  end

  // write request is registered so in-flight samples read the old word
  always_ff @(posedge clk) begin
    if (rst) wr_v <= 1'b0;
    else if (adv) wr_v <= acc && op == OP_WRITE && 32'(texel_index) < 32'(MAX_TEXELS);
    if (adv) begin
      wr_a <= AW'(texel_index);
      wr_d <= texel_argb;
    end
  end

  bts_addr #(.MAX_TEXELS(MAX_TEXELS), .WEIGHT_BITS(WEIGHT_BITS)) u_addr (
    .clk, .rst, .adv, .in_valid(acc && op == OP_SAMPLE), .u_coord, .v_coord,
    .tex_width, .tex_height, .out_valid(a_valid), .idx, .oob, .path, .wx, .wy
  );

  bts_fetch #(.MAX_TEXELS(MAX_TEXELS)) u_fetch (
    .clk, .adv,
    .wr_en(wr_v && adv),
    .wr_addr(wr_a), .wr_data(wr_d), .rd_addr(idx), .rd_data(rd)
  );

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (adv) f_valid <= a_valid;
    if (adv) begin
      oob_r <= oob;
      path_r <= path;
      wx_r <= wx;
      wy_r <= wy;
    end
  end

  always_comb
    for (int i = 0; i < 4; i++) texel[i] = oob_r[i] ? WHITE : rd[i];

  bts_filter #(.WEIGHT_BITS(WEIGHT_BITS)) u_filter (
    .clk, .rst, .adv, .in_valid(f_valid), .texel, .path(path_r), .wx(wx_r),
    .wy(wy_r), .out_valid(fo_valid), .color(color_argb)
  );
  assign out_valid = fo_valid;

  `ASSERT_IMPL(a_stall_only_out, in_stall, out_valid && out_stall)
  `ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(color_argb))
  `ASSERT_NEXT(a_write_no_valid, !in_valid && !a_valid && !f_valid && adv, !u_filter.v1)
endmodule

/* hdl/bts_addr.sv */
// address stage: scales coordinates, forms texel indices and filter path
// uses bts_pkg
module bts_addr #(
  parameter int MAX_TEXELS = bts_pkg::MAX_TEXELS_DEF,
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF,
  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [15:0] u_coord,
  input  logic [15:0] v_coord,
  input  logic [6:0] tex_width,
  input  logic [6:0] tex_height,
  output logic out_valid,
  output logic [3:0][AW-1:0] idx,
  output logic [3:0] oob,
  output bts_pkg::path_t path,
  output logic [WEIGHT_BITS-1:0] wx,
  output logic [WEIGHT_BITS-1:0] wy
);
  import bts_pkg::*;
  logic valid1;
  logic [22:0] pu, pv;
  logic [6:0] w1, h1;
  logic [13:0] total;
  logic [15:0] base, lin [4];
  logic [6:0] x, y;

  always_ff @(posedge clk) begin
    if (rst) valid1 <= 1'b0;
    else if (adv) valid1 <= in_valid;
    if (adv) begin
      pu <= 23'(u_coord) * 23'(tex_width);
      pv <= 23'(v_coord) * 23'(tex_height);
      w1 <= tex_width;
      h1 <= tex_height;
    end
  end

  always_comb begin
    x = pu[22:16];
    y = pv[22:16];
    total = 14'(w1) * 14'(h1);
    base = 16'(y) * 16'(w1) + 16'(x);
    lin[0] = base;
    lin[1] = base + 16'(w1);
    lin[2] = base + 16'd1;
    lin[3] = base + 16'(w1) + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= valid1;
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        idx[i] <= AW'(lin[i]);
        oob[i] <= (lin[i] >= 16'(total)) || (32'(lin[i]) >= 32'(MAX_TEXELS));
      end
      wx <= pu[15:16-WEIGHT_BITS];
      wy <= pv[15:16-WEIGHT_BITS];
      if (pu[15:0] == 16'd0 && pv[15:0] == 16'd0) path <= PATH_RAW;
      else if (pu[15:0] == 16'd0) path <= PATH_VERT;
      else if (pv[15:0] == 16'd0) path <= PATH_HORZ;
      else path <= PATH_BOTH;
    end
  end
endmodule

/* hdl/bts_fetch.sv */
// texel store with four read ports, registered read data
// uses bts_pkg
module bts_fetch #(
  parameter int MAX_TEXELS = bts_pkg::MAX_TEXELS_DEF,
  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
  input  logic clk,
  input  logic adv,
  input  logic wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0][AW-1:0] rd_addr,
  output logic [3:0][31:0] rd_data
);
  import bts_pkg::*;
  logic [31:0] mem0 [MAX_TEXELS];
  logic [31:0] mem1 [MAX_TEXELS];
  logic [31:0] mem2 [MAX_TEXELS];
  logic [31:0] mem3 [MAX_TEXELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem0[wr_addr] <= wr_data;
      mem1[wr_addr] <= wr_data;
      mem2[wr_addr] <= wr_data;
      mem3[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_data[0] <= mem0[rd_addr[0]];
      rd_data[1] <= mem1[rd_addr[1]];
      rd_data[2] <= mem2[rd_addr[2]];
      rd_data[3] <= mem3[rd_addr[3]];
    end
  end
endmodule

/* hdl/bts_filter.sv */
// filter stages: column lerps then row lerp
// uses bts_pkg
module bts_filter #(
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [3:0][31:0] texel,
  input  bts_pkg::path_t path,
  input  logic [WEIGHT_BITS-1:0] wx,
  input  logic [WEIGHT_BITS-1:0] wy,
  output logic out_valid,
  output logic [31:0] color
);
  import bts_pkg::*;
  logic v1;
  logic [31:0] left, right, raw, raw_right;
  path_t p1;
  logic [WEIGHT_BITS-1:0] wx1;
  logic [31:0] res;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      raw <= texel[0];
      raw_right <= texel[2];
      left <= lerp_rgb(texel[0], texel[1], 17'(wy), WEIGHT_BITS);
      right <= lerp_rgb(texel[2], texel[3], 17'(wy), WEIGHT_BITS);
      p1 <= path;
      wx1 <= wx;
    end
  end

  always_comb begin
    case (p1)
      PATH_RAW: res = raw;
      PATH_VERT: res = left;
      PATH_HORZ: res = lerp_rgb(raw, raw_right, 17'(wx1), WEIGHT_BITS);
      PATH_BOTH: res = lerp_rgb(left, right, 17'(wx1), WEIGHT_BITS);
      default: res = raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v1;
    if (adv) color <= res;
  end
endmodule

/* tb/bts_color_checker.sv */
`timescale 1ns / 1ps
// watches the request, color and register ports of the texture sampler,
// predicts each sampled color and compares it; uses bts_pkg
module bts_color_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic op,
  input  logic [15:0] u_coord,
  input  logic [15:0] v_coord,
  input  logic [11:0] texel_index,
  input  logic [31:0] texel_argb,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [31:0] color_argb,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [6:0] cfg_data,
  output int errors,
  output int pending
);
  import bts_pkg::*;

  logic [31:0] texels [4096];
  logic [6:0] width_reg, height_reg;
  logic [31:0] color_fifo [$];

  function automatic logic [31:0] texel_at(int x, int y);
    int idx;
    idx = y * width_reg + x;
    if (idx >= width_reg * height_reg || idx >= MAX_TEXELS_DEF) return WHITE;
    return texels[idx];
  endfunction

  function automatic logic [7:0] mix8(logic [7:0] a, logic [7:0] b, logic [7:0] w);
    logic [16:0] t;
    t = {9'd0, a} * (17'd256 - {9'd0, w}) + {9'd0, b} * {9'd0, w};
    return t[15:8];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] p, logic [31:0] q, logic [7:0] w);
    return {ALPHA_ON, mix8(p[23:16], q[23:16], w), mix8(p[15:8], q[15:8], w),
            mix8(p[7:0], q[7:0], w)};
  endfunction

  function automatic logic [31:0] sampled_color(logic [15:0] u, logic [15:0] v);
    logic [31:0] pu, pv;
    int x, y;
    logic [7:0] wx, wy;
    path_t path;
    pu = u * width_reg;
    pv = v * height_reg;
    x = pu >> 16;
    y = pv >> 16;
    wx = pu[15:8];
    wy = pv[15:8];
    path = path_t'({pu[15:0] != 0, pv[15:0] != 0});
    case (path)
      PATH_RAW: return texel_at(x, y);
      PATH_VERT: return blend(texel_at(x, y), texel_at(x, y + 1), wy);
      PATH_HORZ: return blend(texel_at(x, y), texel_at(x + 1, y), wx);
      default: return blend(blend(texel_at(x, y), texel_at(x, y + 1), wy),
                            blend(texel_at(x + 1, y), texel_at(x + 1, y + 1), wy), wx);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg <= DIM_RESET;
      height_reg <= DIM_RESET;
      color_fifo.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) width_reg <= cfg_data;
        else height_reg <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (op == OP_WRITE) texels[texel_index] = texel_argb;
        else color_fifo.push_back(sampled_color(u_coord, v_coord));
      end
      if (out_valid && !out_stall) begin
        if (color_fifo.size() == 0) begin
          $error("unexpected color_argb %h", color_argb);
          errors <= errors + 1;
        end else begin
          if (color_fifo[0] !== color_argb) begin
            $error("color_argb expected %h actual %h", color_fifo[0], color_argb);
            errors <= errors + 1;
          end
          void'(color_fifo.pop_front());
        end
      end
    end
    pending <= color_fifo.size();
  end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the bilinear texture sampler
// uses bts_pkg, bilinear_texture_sampler_top and bts_color_checker
module tb;
  import bts_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic op = OP_WRITE;
  logic [15:0] u_coord = 0;
  logic [15:0] v_coord = 0;
  logic [11:0] texel_index = 0;
  logic [31:0] texel_argb = 0;
  logic out_stall = 0;
  logic cfg_we = 0;
  logic cfg_index = REG_WIDTH;
  logic [6:0] cfg_data = 0;
  logic in_stall, out_valid;
  logic [31:0] color_argb;
  int errors, pending;

  bit written [4096];
  int cur_w = 64, cur_h = 64;
  int burst_left = 0;
  bit no_gaps = 0;
  bit hold_req = 0;
  int cycles = 0;
  int sent = 0;

  always #1 clk = ~clk;

  bilinear_texture_sampler_top i_dut (.*);

  bts_color_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall patterns, with a long hold on request
  initial begin
    int mode, left;
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 200);
      while (left > 0) begin
        @(posedge clk);
        left--;
        if (hold_req) begin
          hold_req = 0;
          out_stall <= 1;
          repeat (300) @(posedge clk);
          out_stall <= 0;
        end else begin
          case (mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= (left % 4 == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  task automatic offer_request(logic o, logic [15:0] u, logic [15:0] v,
                               logic [11:0] idx, logic [31:0] argb);
    bit stalled;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sent++;
    in_valid <= 1;
    op <= o;
    u_coord <= u;
    v_coord <= v;
    texel_index <= idx;
    texel_argb <= argb;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic write_texel(int idx);
    offer_request(OP_WRITE, 16'($urandom), 16'($urandom), idx[11:0], $urandom);
    written[idx] = 1;
  endtask

  task automatic ensure_texel(int x, int y);
    int idx;
    idx = y * cur_w + x;
    if (idx < cur_w * cur_h && idx < MAX_TEXELS_DEF && !written[idx]) write_texel(idx);
  endtask

  task automatic sample_at(logic [15:0] u, logic [15:0] v);
    logic [31:0] pu, pv;
    int x, y;
    pu = u * cur_w;
    pv = v * cur_h;
    x = pu >> 16;
    y = pv >> 16;
    ensure_texel(x, y);
    if (pv[15:0] != 0) ensure_texel(x, y + 1);
    if (pu[15:0] != 0) ensure_texel(x + 1, y);
    if (pu[15:0] != 0 && pv[15:0] != 0) ensure_texel(x + 1, y + 1);
    offer_request(OP_SAMPLE, u, v, 12'($urandom), $urandom);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom & 16'hFC00);
      3: return 16'(($urandom & 16'hFC00) | $urandom_range(1, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_dims(int w, int h);
    drain();
    cfg_we <= 1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w[6:0];
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h[6:0];
    @(posedge clk);
    cfg_we <= 0;
    cur_w = w;
    cur_h = h;
  endtask

  initial begin
    int dims [10][2] = '{'{64, 64}, '{1, 1}, '{64, 1}, '{1, 64}, '{3, 5},
                         '{7, 4}, '{0, 5}, '{100, 50}, '{127, 127}, '{16, 16}};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: corners, edges, zero fractions and tiny weights
    write_texel(0);
    write_texel(4095);
    offer_request(OP_WRITE, 0, 0, 12'hFFF, 32'hFFFFFFFF);
    offer_request(OP_WRITE, 0, 0, 12'd0, 32'h00000000);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'hFFFF, 16'h0000);
    sample_at(16'h0000, 16'hFFFF);
    sample_at(16'h0400, 16'h0000);
    sample_at(16'h0000, 16'h0400);
    sample_at(16'h0401, 16'h0000);
    sample_at(16'h0000, 16'h0402);
    sample_at(16'h0401, 16'h0403);
    sample_at(16'h8000, 16'h8000);
    sample_at(16'hFC00, 16'hFC00);
    sample_at(16'hFE00, 16'h0000);

    foreach (dims[k]) begin
      set_dims(dims[k][0], dims[k][1]);
      no_gaps = (k % 3 == 2);
      for (int n = 0; sent < (k + 1) * 105; n++) begin
        if ($urandom_range(0, 5) == 0) write_texel($urandom_range(0, 4095));
        else sample_at(pick_coord(), pick_coord());
        if (k == 4 && n == 30) begin
          no_gaps = 1;
          hold_req = 1;
        end
        if (k == 6 && n == 50) drain();
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
